// File: src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ned_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ned_pkg;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       ent;
  } beat_t;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_FLUSH,
    MODE_ENT
  } mode_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  idx;
    logic [15:0] cp;
  } ent_hit_t;

  // Key holds the name right aligned, first letter highest, zero padded.
  function automatic ent_hit_t ent_lookup(input logic [63:0] key);
    ent_hit_t r;
    r = '0;
    case (key)
      "ge"       : r = {1'b1, 8'd0, 16'h2265};
      "gt"       : r = {1'b1, 8'd1, 16'h003E};
      "lt"       : r = {1'b1, 8'd2, 16'h003C};
      "amp"      : r = {1'b1, 8'd3, 16'h0026};
      "quot"     : r = {1'b1, 8'd4, 16'h0022};
      "AElig"    : r = {1'b1, 8'd5, 16'h00C6};
      "Aacute"   : r = {1'b1, 8'd6, 16'h00C1};
      "Acirc"    : r = {1'b1, 8'd7, 16'h00C2};
      "Agrave"   : r = {1'b1, 8'd8, 16'h00C0};
      "Alpha"    : r = {1'b1, 8'd9, 16'h0391};
      "Aring"    : r = {1'b1, 8'd10, 16'h00C5};
      "Atilde"   : r = {1'b1, 8'd11, 16'h00C3};
      "Auml"     : r = {1'b1, 8'd12, 16'h00C4};
      "Beta"     : r = {1'b1, 8'd13, 16'h0392};
      "Ccedil"   : r = {1'b1, 8'd14, 16'h00C7};
      "Chi"      : r = {1'b1, 8'd15, 16'h03A7};
      "Dagger"   : r = {1'b1, 8'd16, 16'h2021};
      "Delta"    : r = {1'b1, 8'd17, 16'h0394};
      "ETH"      : r = {1'b1, 8'd18, 16'h00D0};
      "Eacute"   : r = {1'b1, 8'd19, 16'h00C9};
      "Ecirc"    : r = {1'b1, 8'd20, 16'h00CA};
      "Egrave"   : r = {1'b1, 8'd21, 16'h00C8};
      "Epsilon"  : r = {1'b1, 8'd22, 16'h0395};
      "Eta"      : r = {1'b1, 8'd23, 16'h0397};
      "Euml"     : r = {1'b1, 8'd24, 16'h00CB};
      "Gamma"    : r = {1'b1, 8'd25, 16'h0393};
      "Iacute"   : r = {1'b1, 8'd26, 16'h00CD};
      "Icirc"    : r = {1'b1, 8'd27, 16'h00CE};
      "Igrave"   : r = {1'b1, 8'd28, 16'h00CC};
      "Iota"     : r = {1'b1, 8'd29, 16'h0399};
      "Iuml"     : r = {1'b1, 8'd30, 16'h00CF};
      "Kappa"    : r = {1'b1, 8'd31, 16'h039A};
      "Lambda"   : r = {1'b1, 8'd32, 16'h039B};
      "Mu"       : r = {1'b1, 8'd33, 16'h039C};
      "Ntilde"   : r = {1'b1, 8'd34, 16'h00D1};
      "Nu"       : r = {1'b1, 8'd35, 16'h039D};
      "OElig"    : r = {1'b1, 8'd36, 16'h0152};
      "Oacute"   : r = {1'b1, 8'd37, 16'h00D3};
      "Ocirc"    : r = {1'b1, 8'd38, 16'h00D4};
      "Ograve"   : r = {1'b1, 8'd39, 16'h00D2};
      "Omega"    : r = {1'b1, 8'd40, 16'h03A9};
      "Omicron"  : r = {1'b1, 8'd41, 16'h039F};
      "Oslash"   : r = {1'b1, 8'd42, 16'h00D8};
      "Otilde"   : r = {1'b1, 8'd43, 16'h00D5};
      "Ouml"     : r = {1'b1, 8'd44, 16'h00D6};
      "Phi"      : r = {1'b1, 8'd45, 16'h03A6};
      "Pi"       : r = {1'b1, 8'd46, 16'h03A0};
      "Prime"    : r = {1'b1, 8'd47, 16'h2033};
      "Psi"      : r = {1'b1, 8'd48, 16'h03A8};
      "Rho"      : r = {1'b1, 8'd49, 16'h03A1};
      "Scaron"   : r = {1'b1, 8'd50, 16'h0160};
      "Sigma"    : r = {1'b1, 8'd51, 16'h03A3};
      "THORN"    : r = {1'b1, 8'd52, 16'h00DE};
      "Tau"      : r = {1'b1, 8'd53, 16'h03A4};
      "Theta"    : r = {1'b1, 8'd54, 16'h0398};
      "Uacute"   : r = {1'b1, 8'd55, 16'h00DA};
      "Ucirc"    : r = {1'b1, 8'd56, 16'h00DB};
      "Ugrave"   : r = {1'b1, 8'd57, 16'h00D9};
      "Upsilon"  : r = {1'b1, 8'd58, 16'h03A5};
      "Uuml"     : r = {1'b1, 8'd59, 16'h00DC};
      "Xi"       : r = {1'b1, 8'd60, 16'h039E};
      "Yacute"   : r = {1'b1, 8'd61, 16'h00DD};
      "Yuml"     : r = {1'b1, 8'd62, 16'h0178};
      "Zeta"     : r = {1'b1, 8'd63, 16'h0396};
      "aacute"   : r = {1'b1, 8'd64, 16'h00E1};
      "acirc"    : r = {1'b1, 8'd65, 16'h00E2};
      "acute"    : r = {1'b1, 8'd66, 16'h00B4};
      "aelig"    : r = {1'b1, 8'd67, 16'h00E6};
      "agrave"   : r = {1'b1, 8'd68, 16'h00E0};
      "alefsym"  : r = {1'b1, 8'd69, 16'h2135};
      "alpha"    : r = {1'b1, 8'd70, 16'h03B1};
      "and"      : r = {1'b1, 8'd71, 16'h2227};
      "ang"      : r = {1'b1, 8'd72, 16'h2220};
      "apos"     : r = {1'b1, 8'd73, 16'h0027};
      "aring"    : r = {1'b1, 8'd74, 16'h00E5};
      "asymp"    : r = {1'b1, 8'd75, 16'h2248};
      "atilde"   : r = {1'b1, 8'd76, 16'h00E3};
      "auml"     : r = {1'b1, 8'd77, 16'h00E4};
      "bdquo"    : r = {1'b1, 8'd78, 16'h201E};
      "beta"     : r = {1'b1, 8'd79, 16'h03B2};
      "brvbar"   : r = {1'b1, 8'd80, 16'h00A6};
      "bull"     : r = {1'b1, 8'd81, 16'h2022};
      "cap"      : r = {1'b1, 8'd82, 16'h2229};
      "ccedil"   : r = {1'b1, 8'd83, 16'h00E7};
      "cedil"    : r = {1'b1, 8'd84, 16'h00B8};
      "cent"     : r = {1'b1, 8'd85, 16'h00A2};
      "chi"      : r = {1'b1, 8'd86, 16'h03C7};
      "circ"     : r = {1'b1, 8'd87, 16'h02C6};
      "clubs"    : r = {1'b1, 8'd88, 16'h2663};
      "cong"     : r = {1'b1, 8'd89, 16'h2245};
      "copy"     : r = {1'b1, 8'd90, 16'h00A9};
      "crarr"    : r = {1'b1, 8'd91, 16'h21B5};
      "cup"      : r = {1'b1, 8'd92, 16'h222A};
      "curren"   : r = {1'b1, 8'd93, 16'h00A4};
      "dArr"     : r = {1'b1, 8'd94, 16'h21D3};
      "dagger"   : r = {1'b1, 8'd95, 16'h2020};
      "darr"     : r = {1'b1, 8'd96, 16'h2193};
      "deg"      : r = {1'b1, 8'd97, 16'h00B0};
      "delta"    : r = {1'b1, 8'd98, 16'h03B4};
      "diams"    : r = {1'b1, 8'd99, 16'h2666};
      "divide"   : r = {1'b1, 8'd100, 16'h00F7};
      "eacute"   : r = {1'b1, 8'd101, 16'h00E9};
      "ecirc"    : r = {1'b1, 8'd102, 16'h00EA};
      "egrave"   : r = {1'b1, 8'd103, 16'h00E8};
      "empty"    : r = {1'b1, 8'd104, 16'h2205};
      "emsp"     : r = {1'b1, 8'd105, 16'h2003};
      "ensp"     : r = {1'b1, 8'd106, 16'h2002};
      "epsilon"  : r = {1'b1, 8'd107, 16'h03B5};
      "equiv"    : r = {1'b1, 8'd108, 16'h2261};
      "eta"      : r = {1'b1, 8'd109, 16'h03B7};
      "eth"      : r = {1'b1, 8'd110, 16'h00F0};
      "euml"     : r = {1'b1, 8'd111, 16'h00EB};
      "euro"     : r = {1'b1, 8'd112, 16'h20AC};
      "exist"    : r = {1'b1, 8'd113, 16'h2203};
      "fnof"     : r = {1'b1, 8'd114, 16'h0192};
      "forall"   : r = {1'b1, 8'd115, 16'h2200};
      "frac12"   : r = {1'b1, 8'd116, 16'h00BD};
      "frac14"   : r = {1'b1, 8'd117, 16'h00BC};
      "frac34"   : r = {1'b1, 8'd118, 16'h00BE};
      "frasl"    : r = {1'b1, 8'd119, 16'h2044};
      "gamma"    : r = {1'b1, 8'd120, 16'h03B3};
      "hArr"     : r = {1'b1, 8'd121, 16'h21D4};
      "harr"     : r = {1'b1, 8'd122, 16'h2194};
      "hearts"   : r = {1'b1, 8'd123, 16'h2665};
      "hellip"   : r = {1'b1, 8'd124, 16'h2026};
      "iacute"   : r = {1'b1, 8'd125, 16'h00ED};
      "icirc"    : r = {1'b1, 8'd126, 16'h00EE};
      "iexcl"    : r = {1'b1, 8'd127, 16'h00A1};
      "igrave"   : r = {1'b1, 8'd128, 16'h00EC};
      "image"    : r = {1'b1, 8'd129, 16'h2111};
      "infin"    : r = {1'b1, 8'd130, 16'h221E};
      "int"      : r = {1'b1, 8'd131, 16'h222B};
      "iota"     : r = {1'b1, 8'd132, 16'h03B9};
      "iquest"   : r = {1'b1, 8'd133, 16'h00BF};
      "isin"     : r = {1'b1, 8'd134, 16'h2208};
      "iuml"     : r = {1'b1, 8'd135, 16'h00EF};
      "kappa"    : r = {1'b1, 8'd136, 16'h03BA};
      "lArr"     : r = {1'b1, 8'd137, 16'h21D0};
      "lambda"   : r = {1'b1, 8'd138, 16'h03BB};
      "lang"     : r = {1'b1, 8'd139, 16'h2329};
      "laquo"    : r = {1'b1, 8'd140, 16'h00AB};
      "larr"     : r = {1'b1, 8'd141, 16'h2190};
      "lceil"    : r = {1'b1, 8'd142, 16'h2308};
      "ldquo"    : r = {1'b1, 8'd143, 16'h201C};
      "le"       : r = {1'b1, 8'd144, 16'h2264};
      "lfloor"   : r = {1'b1, 8'd145, 16'h230A};
      "lowast"   : r = {1'b1, 8'd146, 16'h2217};
      "loz"      : r = {1'b1, 8'd147, 16'h25CA};
      "lrm"      : r = {1'b1, 8'd148, 16'h200E};
      "lsaquo"   : r = {1'b1, 8'd149, 16'h2039};
      "lsquo"    : r = {1'b1, 8'd150, 16'h2018};
      "macr"     : r = {1'b1, 8'd151, 16'h00AF};
      "mdash"    : r = {1'b1, 8'd152, 16'h2014};
      "micro"    : r = {1'b1, 8'd153, 16'h00B5};
      "middot"   : r = {1'b1, 8'd154, 16'h00B7};
      "minus"    : r = {1'b1, 8'd155, 16'h2212};
      "mu"       : r = {1'b1, 8'd156, 16'h03BC};
      "nabla"    : r = {1'b1, 8'd157, 16'h2207};
      "nbsp"     : r = {1'b1, 8'd158, 16'h00A0};
      "ndash"    : r = {1'b1, 8'd159, 16'h2013};
      "ne"       : r = {1'b1, 8'd160, 16'h2260};
      "ni"       : r = {1'b1, 8'd161, 16'h220B};
      "not"      : r = {1'b1, 8'd162, 16'h00AC};
      "notin"    : r = {1'b1, 8'd163, 16'h2209};
      "nsub"     : r = {1'b1, 8'd164, 16'h2284};
      "ntilde"   : r = {1'b1, 8'd165, 16'h00F1};
      "nu"       : r = {1'b1, 8'd166, 16'h03BD};
      "oacute"   : r = {1'b1, 8'd167, 16'h00F3};
      "ocirc"    : r = {1'b1, 8'd168, 16'h00F4};
      "oelig"    : r = {1'b1, 8'd169, 16'h0153};
      "ograve"   : r = {1'b1, 8'd170, 16'h00F2};
      "oline"    : r = {1'b1, 8'd171, 16'h203E};
      "omega"    : r = {1'b1, 8'd172, 16'h03C9};
      "omicron"  : r = {1'b1, 8'd173, 16'h03BF};
      "oplus"    : r = {1'b1, 8'd174, 16'h2295};
      "or"       : r = {1'b1, 8'd175, 16'h2228};
      "ordf"     : r = {1'b1, 8'd176, 16'h00AA};
      "ordm"     : r = {1'b1, 8'd177, 16'h00BA};
      "oslash"   : r = {1'b1, 8'd178, 16'h00F8};
      "otilde"   : r = {1'b1, 8'd179, 16'h00F5};
      "otimes"   : r = {1'b1, 8'd180, 16'h2297};
      "ouml"     : r = {1'b1, 8'd181, 16'h00F6};
      "para"     : r = {1'b1, 8'd182, 16'h00B6};
      "part"     : r = {1'b1, 8'd183, 16'h2202};
      "permil"   : r = {1'b1, 8'd184, 16'h2030};
      "perp"     : r = {1'b1, 8'd185, 16'h22A5};
      "phi"      : r = {1'b1, 8'd186, 16'h03C6};
      "pi"       : r = {1'b1, 8'd187, 16'h03C0};
      "piv"      : r = {1'b1, 8'd188, 16'h03D6};
      "plusmn"   : r = {1'b1, 8'd189, 16'h00B1};
      "pound"    : r = {1'b1, 8'd190, 16'h00A3};
      "prime"    : r = {1'b1, 8'd191, 16'h2032};
      "prod"     : r = {1'b1, 8'd192, 16'h220F};
      "prop"     : r = {1'b1, 8'd193, 16'h221D};
      "psi"      : r = {1'b1, 8'd194, 16'h03C8};
      "rArr"     : r = {1'b1, 8'd195, 16'h21D2};
      "radic"    : r = {1'b1, 8'd196, 16'h221A};
      "rang"     : r = {1'b1, 8'd197, 16'h232A};
      "raquo"    : r = {1'b1, 8'd198, 16'h00BB};
      "rarr"     : r = {1'b1, 8'd199, 16'h2192};
      "rceil"    : r = {1'b1, 8'd200, 16'h2309};
      "rdquo"    : r = {1'b1, 8'd201, 16'h201D};
      "real"     : r = {1'b1, 8'd202, 16'h211C};
      "reg"      : r = {1'b1, 8'd203, 16'h00AE};
      "rfloor"   : r = {1'b1, 8'd204, 16'h230B};
      "rho"      : r = {1'b1, 8'd205, 16'h03C1};
      "rlm"      : r = {1'b1, 8'd206, 16'h200F};
      "rsaquo"   : r = {1'b1, 8'd207, 16'h203A};
      "rsquo"    : r = {1'b1, 8'd208, 16'h2019};
      "sbquo"    : r = {1'b1, 8'd209, 16'h201A};
      "scaron"   : r = {1'b1, 8'd210, 16'h0161};
      "sdot"     : r = {1'b1, 8'd211, 16'h22C5};
      "sect"     : r = {1'b1, 8'd212, 16'h00A7};
      "shy"      : r = {1'b1, 8'd213, 16'h00AD};
      "sigma"    : r = {1'b1, 8'd214, 16'h03C3};
      "sigmaf"   : r = {1'b1, 8'd215, 16'h03C2};
      "sim"      : r = {1'b1, 8'd216, 16'h223C};
      "spades"   : r = {1'b1, 8'd217, 16'h2660};
      "sub"      : r = {1'b1, 8'd218, 16'h2282};
      "sube"     : r = {1'b1, 8'd219, 16'h2286};
      "sum"      : r = {1'b1, 8'd220, 16'h2211};
      "sup"      : r = {1'b1, 8'd221, 16'h2283};
      "sup1"     : r = {1'b1, 8'd222, 16'h00B9};
      "sup2"     : r = {1'b1, 8'd223, 16'h00B2};
      "sup3"     : r = {1'b1, 8'd224, 16'h00B3};
      "supe"     : r = {1'b1, 8'd225, 16'h2287};
      "szlig"    : r = {1'b1, 8'd226, 16'h00DF};
      "tau"      : r = {1'b1, 8'd227, 16'h03C4};
      "there4"   : r = {1'b1, 8'd228, 16'h2234};
      "theta"    : r = {1'b1, 8'd229, 16'h03B8};
      "thetasym" : r = {1'b1, 8'd230, 16'h03D1};
      "thinsp"   : r = {1'b1, 8'd231, 16'h2009};
      "thorn"    : r = {1'b1, 8'd232, 16'h00FE};
      "tilde"    : r = {1'b1, 8'd233, 16'h02DC};
      "times"    : r = {1'b1, 8'd234, 16'h00D7};
      "trade"    : r = {1'b1, 8'd235, 16'h2122};
      "uArr"     : r = {1'b1, 8'd236, 16'h21D1};
      "uacute"   : r = {1'b1, 8'd237, 16'h00FA};
      "uarr"     : r = {1'b1, 8'd238, 16'h2191};
      "ucirc"    : r = {1'b1, 8'd239, 16'h00FB};
      "ugrave"   : r = {1'b1, 8'd240, 16'h00F9};
      "uml"      : r = {1'b1, 8'd241, 16'h00A8};
      "upsih"    : r = {1'b1, 8'd242, 16'h03D2};
      "upsilon"  : r = {1'b1, 8'd243, 16'h03C5};
      "uuml"     : r = {1'b1, 8'd244, 16'h00FC};
      "weierp"   : r = {1'b1, 8'd245, 16'h2118};
      "xi"       : r = {1'b1, 8'd246, 16'h03BE};
      "yacute"   : r = {1'b1, 8'd247, 16'h00FD};
      "yen"      : r = {1'b1, 8'd248, 16'h00A5};
      "yuml"     : r = {1'b1, 8'd249, 16'h00FF};
      "zeta"     : r = {1'b1, 8'd250, 16'h03B6};
      "zwj"      : r = {1'b1, 8'd251, 16'h200D};
      "zwnj"     : r = {1'b1, 8'd252, 16'h200C};
      default    : r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/html_named_entity_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Ports                                       Beat
// in       input      in_valid in_stall in_text_byte in_stream_end  one text byte
// out      output     out_valid out_stall out_byte out_from_entity out_run_last  one byte
//
// A text byte is taken when in_valid is high and in_stall is low; its results land in
// the burst register and leave one beat per cycle while out_stall is low, so a byte with
// n results (n up to MAX_NAME_LEN+2) holds in_stall until its last beat leaves.
// Bytes that make no result or one result flow at one per cycle while out_stall is low.
// Reset (rst_n low, synchronous) closes any open name and empties the burst.
// out_stall freezes the current beat; in_stall rises only while a burst remains.
module html_named_entity_decoder_top #(
  parameter int MAX_NAME_LEN  = 8,
  parameter int TABLE_ENTRIES = 253
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_stream_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_from_entity,
  output logic            out_run_last
);

  localparam int SLOTS = MAX_NAME_LEN + 2;
  localparam int LEN_W = $clog2(SLOTS + 1);

  ned_pkg::beat_t   burst [SLOTS];
  logic [LEN_W-1:0] burst_len;
  logic             busy;
  logic             take;
  ned_pkg::beat_t   beat;

  assign in_stall = busy;
  assign take     = in_valid && !busy;

  // name state, table match and burst construction
  ned_core #(
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .text_byte (in_text_byte),
    .stream_end(in_stream_end),
    .burst     (burst),
    .burst_len (burst_len)
  );

  // result register: replays the burst beat by beat
  ned_burst #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_burst (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .burst    (burst),
    .burst_len(burst_len),
    .busy     (busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (beat),
    .out_last (out_run_last)
  );

  assign out_byte        = beat.data;
  assign out_from_entity = beat.ent;

`include "assert_macros.svh"

  // mid-burst the input must be held off
  `ASSERT_IMPL(a_stall_mid_burst, out_valid && !out_run_last, in_stall, "input open mid-burst")
  // a burst never ends early
  `ASSERT_NEXT(a_burst_continues, out_valid && !out_stall && !out_run_last, out_valid, "burst cut")
  // an accepted byte always finds the output free or draining its last beat
  `ASSERT_IMPL(a_take_free, in_valid && !in_stall, !out_valid || (out_run_last && !out_stall),
               "byte taken over pending beats")

endmodule
`default_nettype wire

// File: src/ned_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Name collection state and per-byte burst builder.
module ned_core #(
  parameter int MAX_NAME_LEN  = 8,
  parameter int TABLE_ENTRIES = 253,
  localparam int SLOTS = MAX_NAME_LEN + 2,
  localparam int LEN_W = $clog2(SLOTS + 1),
  localparam int CNT_W = $clog2(MAX_NAME_LEN + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 take,
  input  wire logic [7:0]           text_byte,
  input  wire logic                 stream_end,
  output ned_pkg::beat_t            burst [SLOTS],
  output logic      [LEN_W-1:0]     burst_len
);

  logic             in_entity_r, in_entity_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       name_r [MAX_NAME_LEN];
  logic [63:0]      key_r, key_nxt;
  logic             store;
  logic [7:0]       tail;
  ned_pkg::mode_t   mode;
  ned_pkg::ent_hit_t hit;
  logic             match;
  logic             alnum;
  logic [7:0]       utf [3];
  logic [1:0]       utf_len;

  assign alnum = (text_byte inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});

  always_comb begin
    hit   = ned_pkg::ent_lookup(key_r);
    match = hit.hit && (int'(hit.idx) < TABLE_ENTRIES) && (count_r != '0)
            && (int'(count_r) <= 8);
  end

  // UTF-8 encoding of the matched code point
  always_comb begin
    utf[0]  = hit.cp[7:0];
    utf[1]  = 8'h00;
    utf[2]  = 8'h00;
    utf_len = 2'd1;
    if (hit.cp >= 16'h0800) begin
      utf[0]  = {4'hE, hit.cp[15:12]};
      utf[1]  = {2'b10, hit.cp[11:6]};
      utf[2]  = {2'b10, hit.cp[5:0]};
      utf_len = 2'd3;
    end else if (hit.cp >= 16'h0080) begin
      utf[0]  = {3'b110, hit.cp[10:6]};
      utf[1]  = {2'b10, hit.cp[5:0]};
      utf_len = 2'd2;
    end
  end

  always_comb begin
    mode          = ned_pkg::MODE_PASS;
    burst_len     = '0;
    tail          = text_byte;
    in_entity_nxt = in_entity_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    store         = 1'b0;
    if (!in_entity_r) begin
      if (text_byte == ned_pkg::CH_AMP) begin
        in_entity_nxt = 1'b1;
        count_nxt     = '0;
        key_nxt       = '0;
        if (stream_end) begin
          mode          = ned_pkg::MODE_FLUSH;
          burst_len     = LEN_W'(1);
          in_entity_nxt = 1'b0;
        end
      end else begin
        burst_len = LEN_W'(1);
      end
    end else if (alnum) begin
      if (int'(count_r) < MAX_NAME_LEN && !stream_end) begin
        store     = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        key_nxt   = {key_r[55:0], text_byte};
      end else begin
        // name full or stream ends: the byte rides behind the flushed name
        mode          = ned_pkg::MODE_FLUSH;
        burst_len     = LEN_W'(count_r) + LEN_W'(2);
        in_entity_nxt = 1'b0;
        count_nxt     = '0;
      end
    end else if (text_byte == ned_pkg::CH_SEMI) begin
      if (match) begin
        mode      = ned_pkg::MODE_ENT;
        burst_len = LEN_W'(utf_len);
      end else begin
        mode      = ned_pkg::MODE_FLUSH;
        burst_len = LEN_W'(count_r) + LEN_W'(2);
      end
      in_entity_nxt = 1'b0;
      count_nxt     = '0;
    end else if (text_byte == ned_pkg::CH_AMP) begin
      mode      = ned_pkg::MODE_FLUSH;
      burst_len = LEN_W'(count_r) + LEN_W'(1);
      count_nxt = '0;
      key_nxt   = '0;
      if (stream_end) begin
        // new empty name flushed at once
        burst_len     = LEN_W'(count_r) + LEN_W'(2);
        in_entity_nxt = 1'b0;
      end
    end else begin
      mode          = ned_pkg::MODE_FLUSH;
      burst_len     = LEN_W'(count_r) + LEN_W'(2);
      in_entity_nxt = 1'b0;
      count_nxt     = '0;
    end
  end

  for (genvar j = 0; j < SLOTS; j++) begin : g_slot
    logic [7:0] name_at;
    if (j >= 1 && j <= MAX_NAME_LEN) begin : g_name
      assign name_at = name_r[j-1];
    end else begin : g_none
      assign name_at = 8'h00;
    end
    always_comb begin
      burst[j].data = tail;
      burst[j].ent  = 1'b0;
      case (mode)
        ned_pkg::MODE_FLUSH: begin
          if (j == 0) begin
            burst[j].data = ned_pkg::CH_AMP;
          end else if (j <= int'(count_r)) begin
            burst[j].data = name_at;
          end
        end
        ned_pkg::MODE_ENT: begin
          if (j < 3) begin
            burst[j].data = utf[j];
          end
          burst[j].ent = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_entity_r <= 1'b0;
      count_r     <= '0;
    end else if (take) begin
      in_entity_r <= in_entity_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key_r <= key_nxt;
      if (store) begin
        name_r[count_r[$clog2(MAX_NAME_LEN)-1:0]] <= text_byte;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/ned_burst.sv
`timescale 1ns / 1ps
`default_nettype none
// Result register file: holds one burst and plays it out a beat per cycle while out_stall is low.
module ned_burst #(
  parameter int MAX_NAME_LEN = 8,
  localparam int SLOTS = MAX_NAME_LEN + 2,
  localparam int LEN_W = $clog2(SLOTS + 1),
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  ned_pkg::beat_t        burst [SLOTS],
  input  wire logic [LEN_W-1:0] burst_len,
  output logic                  busy,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ned_pkg::beat_t        out_beat,
  output logic                  out_last
);

  ned_pkg::beat_t   beats_r [SLOTS];
  logic [LEN_W-1:0] len_r, pos_r;
  logic             fire;

  assign out_valid = (pos_r != len_r);
  assign out_last  = (pos_r + LEN_W'(1) == len_r);
  assign out_beat  = beats_r[pos_r[IDX_W-1:0]];
  assign fire      = out_valid && !out_stall;
  // free when empty or the final beat leaves this cycle
  assign busy      = out_valid && !(fire && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pos_r <= '0;
    end else if (load) begin
      len_r <= burst_len;
      pos_r <= '0;
    end else if (fire) begin
      pos_r <= pos_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beats_r <= burst;
    end
  end

endmodule
`default_nettype wire
